### hw/rtl/rar_pkg.sv
package rar_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int RES_W = 32;
  localparam int SHIFT_W = $clog2(RES_W);

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic mul_c;
    logic gcd_init;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } rar_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic den_zero;
    logic gcd_done;
    logic div_last;
  } rar_status_t;

  function automatic logic [RES_W-1:0] mag(input logic [RES_W-1:0] v);
    mag = v[RES_W-1] ? RES_W'(0) - v : v;
  endfunction

endpackage

### hw/rtl/rar_datapath.sv
module rar_datapath
  import rar_pkg::*;
(
  input  logic                            clk,
  input  rar_cmd_t                        cmd,
  output rar_status_t                     status,
  input  logic [1:0]                      in_func,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic signed [RES_W-1:0]         out_res_num,
  output logic signed [RES_W-1:0]         out_res_den,
  output logic                            out_zero_den
);

  func_t              func_r;
  logic [RES_W-1:0]   an_r, ad_r, bn_r, bd_r;
  logic [RES_W-1:0]   num_r, den_r;
  logic [RES_W-1:0]   x_r, y_r, g_r;
  logic [SHIFT_W-1:0] k_r;
  logic [RES_W-1:0]   qn_r, qd_r, rn_r, rd_r;
  logic [SHIFT_W-1:0] cnt_r;
  logic [RES_W-1:0]   res_num_r, res_den_r;
  logic               zero_den_r;

  logic [RES_W-1:0]   mul_x, mul_y, prod;
  logic [RES_W-1:0]   diff_xy, diff_yx;
  logic [RES_W:0]     rem_n, rem_d;
  logic               ge_n, ge_d;

  // Operand multiplexing onto the shared multiplier.
  always_comb begin
    mul_x = cmd.mul_a ? an_r : ad_r;
    if (cmd.mul_a) begin
      mul_y = (func_r == FUNC_MUL) ? bn_r : bd_r;
    end else if (cmd.mul_b) begin
      mul_y = bn_r;
    end else begin
      mul_y = (func_r == FUNC_DIV) ? bn_r : bd_r;
    end
  end

  assign prod = mul_x * mul_y;

  assign diff_xy = x_r - y_r;
  assign diff_yx = y_r - x_r;

  assign rem_n = {rn_r, qn_r[RES_W-1]};
  assign rem_d = {rd_r, qd_r[RES_W-1]};
  assign ge_n  = rem_n >= {1'b0, g_r};
  assign ge_d  = rem_d >= {1'b0, g_r};

  assign status.den_zero = (den_r == '0);
  assign status.gcd_done = (x_r == '0) || (y_r == '0);
  assign status.div_last = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func_t'(in_func);
      an_r   <= RES_W'(in_a_num);
      ad_r   <= RES_W'(in_a_den);
      bn_r   <= RES_W'(in_b_num);
      bd_r   <= RES_W'(in_b_den);
    end

    if (cmd.mul_a) begin
      num_r <= prod;
    end else if (cmd.mul_b) begin
      if (func_r == FUNC_ADD) begin
        num_r <= num_r + prod;
      end else if (func_r == FUNC_SUB) begin
        num_r <= num_r - prod;
      end
    end
    if (cmd.mul_c) begin
      den_r <= prod;
    end

    // Binary gcd: strip common factors of two into k_r, then subtract odd from odd.
    if (cmd.gcd_init) begin
      x_r <= mag(num_r);
      y_r <= mag(den_r);
      k_r <= '0;
    end else if (cmd.gcd_step) begin
      priority if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + SHIFT_W'(1);
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r >= y_r) begin
        x_r <= diff_xy >> 1;
      end else begin
        y_r <= diff_yx >> 1;
      end
    end

    // Both magnitudes are divided by the gcd side by side, one bit a cycle.
    if (cmd.div_init) begin
      g_r   <= (x_r | y_r) << k_r;
      qn_r  <= mag(num_r);
      qd_r  <= mag(den_r);
      rn_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '1;
    end else if (cmd.div_step) begin
      rn_r  <= ge_n ? RES_W'(rem_n - {1'b0, g_r}) : rem_n[RES_W-1:0];
      rd_r  <= ge_d ? RES_W'(rem_d - {1'b0, g_r}) : rem_d[RES_W-1:0];
      qn_r  <= {qn_r[RES_W-2:0], ge_n};
      qd_r  <= {qd_r[RES_W-2:0], ge_d};
      cnt_r <= cnt_r - SHIFT_W'(1);
    end

    if (cmd.out_load) begin
      if (status.den_zero) begin
        res_num_r  <= num_r;
        res_den_r  <= '0;
        zero_den_r <= 1'b1;
      end else begin
        res_num_r  <= num_r[RES_W-1] ? RES_W'(0) - qn_r : qn_r;
        res_den_r  <= den_r[RES_W-1] ? RES_W'(0) - qd_r : qd_r;
        zero_den_r <= 1'b0;
      end
    end
  end

  assign out_res_num  = res_num_r;
  assign out_res_den  = res_den_r;
  assign out_zero_den = zero_den_r;

endmodule

### hw/rtl/rar_ctrl.sv
module rar_ctrl
  import rar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  rar_status_t status,
  output rar_cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL_A = 8'b0000_0010,
    ST_MUL_B = 8'b0000_0100,
    ST_MUL_C = 8'b0000_1000,
    ST_CHECK = 8'b0001_0000,
    ST_GCD   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.mul_c = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.den_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_nxt    = ST_GCD;
        end
      end
      ST_GCD: begin
        if (status.gcd_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/rational_arith_reduce.sv
// Adds, subtracts, multiplies or divides two signed fractions and reduces the
// result by the gcd of the magnitudes of its numerator and denominator; signs
// are kept as computed and all raw arithmetic wraps at 32 bits. One transaction
// is worked on at a time: a zero denominator is passed through unreduced with
// out_zero_den set; otherwise the work is three steps on the shared multiplier,
// a binary gcd at one step per cycle, its step count depending on the operand
// bits, and a bit-serial restoring divide.
// The result sits in an output register, so the next input transaction is
// taken while the previous result still waits for out_ready.
module rational_arith_reduce
  import rar_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [RES_W-1:0]         out_res_num,
  output logic signed [RES_W-1:0]         out_res_den,
  output logic                            out_zero_den
);

  rar_cmd_t    cmd;
  rar_status_t status;

  rar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rar_datapath u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .in_func     (in_func),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_zero_den(out_zero_den)
  );

endmodule

### hw/rtl/rar_checker.sv
module rar_checker
  import rar_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [RES_W-1:0] out_res_num,
  input logic signed [RES_W-1:0] out_res_den,
  input logic                    out_zero_den
);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num)
      && $stable(out_res_den) && $stable(out_zero_den))
    else $error("result changed while stalled");

  // Only one transaction is in flight: ready drops after an accept.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_den |-> out_res_den == '0)
    else $error("zero denominator flag with nonzero denominator");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_den |-> out_res_den != '0)
    else $error("reduced denominator is zero");

  // A zero numerator reduces the denominator to a unit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_den && out_res_num == '0
      |-> out_res_den == RES_W'(1) || out_res_den == '1)
    else $error("zero numerator not reduced to unit denominator");

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (.*);
